FILE: rtl/taag_pkg.sv
// shared widths, register indexes and the configuration bundle of the tiled address generator
package taag_pkg;

    localparam int AXIS_POINTS_DEF = 4096;
    localparam int MAX_AXES_DEF    = 4;
    localparam int NUM_AXES        = 4;
    localparam int LEN_W           = 13;
    localparam int AXC_W           = 3;
    localparam int ADDR_W          = 48;
    localparam int HALF_W          = ADDR_W / 2;
    localparam int CFG_IDX_W       = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXIS_COUNT = 3'd0,
        REG_TILE_LEN_X = 3'd1,
        REG_TILE_LEN_Y = 3'd2,
        REG_TILE_LEN_Z = 3'd3,
        REG_TILE_LEN_W = 3'd4,
        REG_TILES_X    = 3'd5,
        REG_TILES_Y    = 3'd6,
        REG_TILES_Z    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [NUM_AXES-1:0]            axis_on;
        logic [NUM_AXES-1:0][LEN_W-1:0] len;
        logic [LEN_W-1:0]               wo1;
        logic [2*LEN_W-1:0]             wo2;
        logic [3*LEN_W-1:0]             wo3;
        logic [LEN_W-1:0]               wt1;
        logic [2*LEN_W-1:0]             wt2;
        logic [3*LEN_W-1:0]             wt3;
        logic [ADDR_W-1:0]              vol;
    } t_cfg;

endpackage

FILE: rtl/taag_cfg.sv
// configuration registers and the registered radix weights derived from them
module taag_cfg
    import taag_pkg::*;
#(
    parameter int MAX_AXES = MAX_AXES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LEN_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    localparam logic [AXC_W-1:0] MAXA = AXC_W'(MAX_AXES);
    localparam logic [AXC_W-1:0] MINA = AXC_W'(2);

    logic [AXC_W-1:0] r_axc;
    logic [NUM_AXES-1:0][LEN_W-1:0] r_len;
    logic [NUM_AXES-2:0][LEN_W-1:0] r_cnt;

    logic [AXC_W-1:0] axn;
    logic [NUM_AXES-1:0][LEN_W-1:0] len;
    logic [NUM_AXES-2:0][LEN_W-1:0] cnt;
    logic [NUM_AXES-1:0] on;

    logic [LEN_W-1:0]   r_l0, r_c0, r_l2, r_c2;
    logic [2*LEN_W-1:0] r_l01, r_l23, r_c01;
    logic [3*LEN_W-1:0] r_q3, r_p3;
    logic [ADDR_W-1:0]  r_vol;
    logic [2*LEN_W-1:0] l01, l23, c01;
    logic [3*LEN_W-1:0] q3, p3;
    logic [4*LEN_W-1:0] vol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axc <= AXC_W'(2);
            r_len <= {NUM_AXES{LEN_W'(1)}};
            r_cnt <= {(NUM_AXES-1){LEN_W'(1)}};
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_AXIS_COUNT: r_axc    <= i_cfg_data[AXC_W-1:0];
                REG_TILE_LEN_X: r_len[0] <= i_cfg_data;
                REG_TILE_LEN_Y: r_len[1] <= i_cfg_data;
                REG_TILE_LEN_Z: r_len[2] <= i_cfg_data;
                REG_TILE_LEN_W: r_len[3] <= i_cfg_data;
                REG_TILES_X:    r_cnt[0] <= i_cfg_data;
                REG_TILES_Y:    r_cnt[1] <= i_cfg_data;
                REG_TILES_Z:    r_cnt[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_axc < MINA) begin
            axn = MINA;
        end else if (r_axc > MAXA) begin
            axn = MAXA;
        end else begin
            axn = r_axc;
        end
        for (int k = 0; k < NUM_AXES; k++) begin
            on[k]  = AXC_W'(k) < axn;
            len[k] = (!on[k] || r_len[k] == '0) ? LEN_W'(1) : r_len[k];
        end
        // tile count of the last used axis and above no longer matters
        for (int k = 0; k < NUM_AXES - 1; k++) begin
            cnt[k] = (AXC_W'(k + 1) >= axn) ? LEN_W'(1) : r_cnt[k];
        end
    end

    assign l01 = len[0] * len[1];
    assign l23 = len[2] * len[3];
    assign c01 = cnt[0] * cnt[1];
    assign q3  = r_l01 * r_l2;
    assign p3  = r_c01 * r_c2;
    assign vol = r_l01 * r_l23;

    always_ff @(posedge i_clk) begin
        r_l0  <= len[0];
        r_l2  <= len[2];
        r_c0  <= cnt[0];
        r_c2  <= cnt[2];
        r_l01 <= l01;
        r_l23 <= l23;
        r_c01 <= c01;
        r_q3  <= q3;
        r_p3  <= p3;
        r_vol <= ADDR_W'(vol);
    end

    assign o_cfg.axis_on = on;
    assign o_cfg.len     = len;
    assign o_cfg.wo1     = r_l0;
    assign o_cfg.wo2     = r_l01;
    assign o_cfg.wo3     = r_q3;
    assign o_cfg.wt1     = r_c0;
    assign o_cfg.wt2     = r_c01;
    assign o_cfg.wt3     = r_p3;
    assign o_cfg.vol     = r_vol;

endmodule

FILE: rtl/taag_div.sv
// pipelined restoring divider for one axis, one quotient bit per stage
module taag_div
    import taag_pkg::*;
#(
    parameter int COORD_W = 12
) (
    input  logic               i_clk,
    input  logic [COORD_W-1:0] i_coord,
    input  logic [LEN_W-1:0]   i_div,
    output logic [COORD_W-1:0] o_quot,
    output logic [LEN_W-1:0]   o_rem
);

    logic [COORD_W-1:0][LEN_W-1:0]   r_rem;
    logic [COORD_W-1:0][COORD_W-1:0] r_dq;

    for (genvar k = 0; k < COORD_W; k++) begin : g_step
        logic [LEN_W-1:0]   cur_rem;
        logic [COORD_W-1:0] cur_dq;
        logic [LEN_W:0]     trial;
        logic               ge;
        logic [COORD_W:0]   shifted;
        logic [LEN_W:0]     diff;

        if (k == 0) begin : g_first
            assign cur_rem = '0;
            assign cur_dq  = i_coord;
        end else begin : g_next
            assign cur_rem = r_rem[k-1];
            assign cur_dq  = r_dq[k-1];
        end

        assign trial   = {cur_rem, cur_dq[COORD_W-1]};
        assign ge      = trial >= {1'b0, i_div};
        assign diff    = trial - {1'b0, i_div};
        assign shifted = {cur_dq, ge};

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
            r_dq[k]  <= shifted[COORD_W-1:0];
        end
    end

    assign o_quot = r_dq[COORD_W-1];
    assign o_rem  = r_rem[COORD_W-1];

endmodule

FILE: rtl/taag_mix.sv
// mixed-radix combine of offsets and tile indices, then scale by tile volume
module taag_mix
    import taag_pkg::*;
#(
    parameter int COORD_W = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [NUM_AXES-1:0][COORD_W-1:0]  i_quot,
    input  logic [NUM_AXES-1:0][LEN_W-1:0]    i_rem,
    input  t_cfg                              i_cfg,
    output logic                              o_valid,
    output logic [ADDR_W-1:0]                 o_addr
);

    localparam int DEPTH = 5;

    logic [DEPTH-1:0] r_vld;
    logic [NUM_AXES-1:0][ADDR_W-1:0] r_po, r_pt;
    logic [ADDR_W-1:0] r_so01, r_so23, r_st01, r_st23;
    logic [ADDR_W-1:0] r_off, r_tn, r_off4, r_pll;
    logic [HALF_W-1:0] r_plh, r_phl;
    logic [ADDR_W-1:0] r_addr;

    logic [2*LEN_W-1:0]         po1;
    logic [3*LEN_W-1:0]         po2;
    logic [4*LEN_W-1:0]         po3;
    logic [COORD_W+LEN_W-1:0]   pt1;
    logic [COORD_W+2*LEN_W-1:0] pt2;
    logic [COORD_W+3*LEN_W-1:0] pt3;
    logic [ADDR_W-1:0]          pll, plh, phl;
    logic [HALF_W-1:0]          mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    assign po1 = i_rem[1] * i_cfg.wo1;
    assign po2 = i_rem[2] * i_cfg.wo2;
    assign po3 = i_rem[3] * i_cfg.wo3;
    assign pt1 = i_quot[1] * i_cfg.wt1;
    assign pt2 = i_quot[2] * i_cfg.wt2;
    assign pt3 = i_quot[3] * i_cfg.wt3;

    // tile number times volume, low half by high half cross terms only matter below 2^48
    assign pll = r_tn[HALF_W-1:0] * i_cfg.vol[HALF_W-1:0];
    assign plh = r_tn[HALF_W-1:0] * i_cfg.vol[ADDR_W-1:HALF_W];
    assign phl = r_tn[ADDR_W-1:HALF_W] * i_cfg.vol[HALF_W-1:0];
    assign mid = r_plh + r_phl;

    always_ff @(posedge i_clk) begin
        r_po[0] <= ADDR_W'(i_rem[0]);
        r_po[1] <= ADDR_W'(po1);
        r_po[2] <= ADDR_W'(po2);
        r_po[3] <= ADDR_W'(po3);
        r_pt[0] <= ADDR_W'(i_quot[0]);
        r_pt[1] <= ADDR_W'(pt1);
        r_pt[2] <= ADDR_W'(pt2);
        r_pt[3] <= ADDR_W'(pt3);

        r_so01 <= r_po[0] + r_po[1];
        r_so23 <= r_po[2] + r_po[3];
        r_st01 <= r_pt[0] + r_pt[1];
        r_st23 <= r_pt[2] + r_pt[3];

        r_off <= r_so01 + r_so23;
        r_tn  <= r_st01 + r_st23;

        r_off4 <= r_off;
        r_pll  <= pll;
        r_plh  <= plh[HALF_W-1:0];
        r_phl  <= phl[HALF_W-1:0];

        r_addr <= r_off4 + r_pll + {mid, {HALF_W{1'b0}}};
    end

    assign o_valid = r_vld[DEPTH-1];
    assign o_addr  = r_addr;

endmodule

FILE: rtl/tiled_array_address_generator.sv
// top level of the tiled array address generator
//
// Turns a point coordinate into the word address of that point in a file
// stored as tiles. A request is taken at each rising edge with i_start high
// and o_busy low; o_busy stays low, so one request per cycle is sustained.
// Each axis coordinate below MAX_AXES runs through its own pipelined restoring
// divider, one quotient bit per stage: COORD_W divider stages, then products,
// two adder levels, the volume partial products and the final sum.
// The result appears on o_word_address for exactly one cycle with o_done
// high; the receiver cannot stall, so nothing is held back.
// Configuration writes use i_cfg_valid / o_cfg_ready, index and data;
// o_cfg_ready stays high, so every write is taken; write only while no
// request is in flight. The derived weights are registered after a write.
// Synchronous reset empties the pipeline and restores the 2D layout with
// all tile lengths and tile counts at one.
module tiled_array_address_generator
    import taag_pkg::*;
#(
    parameter int AXIS_POINTS = AXIS_POINTS_DEF,
    parameter int MAX_AXES    = MAX_AXES_DEF,
    localparam int COORD_W    = $clog2(AXIS_POINTS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [COORD_W-1:0]   i_coord_x,
    input  logic [COORD_W-1:0]   i_coord_y,
    input  logic [COORD_W-1:0]   i_coord_z,
    input  logic [COORD_W-1:0]   i_coord_w,
    output logic                 o_done,
    output logic [ADDR_W-1:0]    o_word_address,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LEN_W-1:0]     i_cfg_data
);

    t_cfg cfg;
    logic accept;
    logic [COORD_W-1:0] r_dv;
    logic [COORD_W:0]   dv_shift;
    logic [NUM_AXES-1:0][COORD_W-1:0] coord, coord_m, quot;
    logic [NUM_AXES-1:0][LEN_W-1:0]   rem;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    taag_cfg #(.MAX_AXES(MAX_AXES)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // valid bits alongside the divider stages
    assign dv_shift = {r_dv, accept};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else begin
            r_dv <= dv_shift[COORD_W-1:0];
        end
    end

    assign coord = {i_coord_w, i_coord_z, i_coord_y, i_coord_x};

    for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
        // unused axes enter as zero
        assign coord_m[k] = cfg.axis_on[k] ? coord[k] : '0;
        if (k < MAX_AXES) begin : g_lane
            taag_div #(.COORD_W(COORD_W)) u_div (
                .i_clk   (i_clk),
                .i_coord (coord_m[k]),
                .i_div   (cfg.len[k]),
                .o_quot  (quot[k]),
                .o_rem   (rem[k])
            );
        end else begin : g_none
            assign quot[k] = '0;
            assign rem[k]  = '0;
        end
    end

    taag_mix #(.COORD_W(COORD_W)) u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_dv[COORD_W-1]),
        .i_quot  (quot),
        .i_rem   (rem),
        .i_cfg   (cfg),
        .o_valid (o_done),
        .o_addr  (o_word_address)
    );

endmodule

FILE: rtl/taag_chk.sv
// port-level checks of the tiled address generator and their binding
module taag_chk
    import taag_pkg::*;
#(
    parameter int AXIS_POINTS = AXIS_POINTS_DEF,
    localparam int COORD_W    = $clog2(AXIS_POINTS)
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_start,
    input logic                 o_busy,
    input logic [COORD_W-1:0]   i_coord_x,
    input logic [COORD_W-1:0]   i_coord_y,
    input logic [COORD_W-1:0]   i_coord_z,
    input logic [COORD_W-1:0]   i_coord_w,
    input logic                 o_done,
    input logic [ADDR_W-1:0]    o_word_address
);

    localparam int LAT = COORD_W + 5;

    // every accepted request is matched by an o_done pulse
    a_req_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT o_done)
        else $error("request did not complete after fixed latency");

    // no result without a request
    a_done_req : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy && i_rst_n, LAT))
        else $error("result without matching request");

    // the origin maps to word zero in any layout
    a_origin : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_coord_x == '0 && i_coord_y == '0 &&
         i_coord_z == '0 && i_coord_w == '0) |-> ##LAT (o_word_address == '0))
        else $error("origin did not map to word zero");

endmodule

bind tiled_array_address_generator taag_chk #(.AXIS_POINTS(AXIS_POINTS)) u_taag_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .i_coord_x      (i_coord_x),
    .i_coord_y      (i_coord_y),
    .i_coord_z      (i_coord_z),
    .i_coord_w      (i_coord_w),
    .o_done         (o_done),
    .o_word_address (o_word_address)
);
